// ----- hw/rtl/terminal_escape_sequence_filter_macros.svh -----
// assertion macros for the terminal escape sequence filter
`ifndef TERMINAL_ESCAPE_SEQUENCE_FILTER_MACROS_SVH
`define TERMINAL_ESCAPE_SEQUENCE_FILTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TESF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define TESF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/tesf_pkg.sv -----
// types, byte codes and mode codes shared by the escape sequence filter
`default_nettype none
package tesf_pkg;

   localparam int PARAM_WIDTH = 16;
   localparam logic [PARAM_WIDTH-1:0] PARAM_MAX = '1;
   localparam int COUNT_WIDTH = 16;

   // parser modes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_ESC  = 2'd1;
   localparam logic [1:0] MODE_CSI  = 2'd2;
   localparam logic [1:0] MODE_SKIP = 2'd3;

   // result kinds
   localparam logic ACT_CHAR   = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   // byte codes
   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SO    = 8'h0E;
   localparam logic [7:0] CH_SI    = 8'h0F;
   localparam logic [7:0] CH_CAN   = 8'h18;
   localparam logic [7:0] CH_SUB   = 8'h1A;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_CSI   = 8'h9B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_UPD   = 8'h44;
   localparam logic [7:0] CH_UPE   = 8'h45;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_LOWC  = 8'h63;

   typedef struct packed {
      logic [1:0]             mode;
      logic [7:0]             sep_count;
      logic [PARAM_WIDTH-1:0] first_param;
   } tesf_state_type;

   typedef struct packed {
      logic                   valid;
      logic                   action;
      logic [7:0]             out_char;
      logic [COUNT_WIDTH-1:0] blank_count;
   } tesf_result_type;

endpackage
`default_nettype wire

// ----- hw/rtl/terminal_escape_sequence_filter.sv -----
// top level of the terminal escape sequence filter: input stage, parser, result stage
//
// usage
// - req channel carries one byte of the display stream per item in req_tdata
// - rsp channel carries zero or one result per input item: rsp_tuser is the
//   action (0 display rsp_tdata[7:0], 1 insert rsp_tdata[23:8] blanks at cursor)
// - an accepted item first waits in the input register, then the parser decode
//   of it lands in the result register
// - one item per cycle unless stalled; the parser state is a single register
//   updated as an item leaves the input register, so bytes follow back to back
// - bytes that give no result (escape sequences, dropped controls) move on
//   without using the result register
// - when the receiver stalls, the result register holds and the input
//   register fills; req_tready drops only when the held input item would
//   give a result while the result register is full and not draining
// - synchronous reset empties both stages and returns the parser to idle with
//   cleared parameters
`default_nettype none
`include "terminal_escape_sequence_filter_macros.svh"
module terminal_escape_sequence_filter
   import tesf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_char, [23:8] blank_count
   output logic             rsp_tuser    // [0] action
);

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // parser state
   tesf_state_type state_ff, state_in;

   // result stage
   logic                   out_valid_ff, out_valid_in;
   logic                   out_action_ff;
   logic [7:0]             out_char_ff;
   logic [COUNT_WIDTH-1:0] out_count_ff;

   tesf_result_type result;
   logic            out_free;
   logic            advance;

   tesf_parser u_parser (
      .in_byte   (in_byte_ff),
      .cur_state (state_ff),
      .nxt_state (state_in),
      .result    (result)
   );

   // result slot is free when empty or draining this cycle
   assign out_free = !out_valid_ff || rsp_tready;
   // an item with no result may leave even when the result slot is held
   assign advance  = in_valid_ff && (out_free || !result.valid);

   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   assign out_valid_in = (advance && result.valid) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_IDLE, sep_count: '0, first_param: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance)
            state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready)
         in_byte_ff <= req_tdata;
      if (advance && result.valid) begin
         out_action_ff <= result.action;
         out_char_ff   <= result.out_char;
         out_count_ff  <= result.blank_count;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_action_ff;
   assign rsp_tdata  = {out_count_ff, out_char_ff};

   // decode of the held item and the result slot, for the checks
   logic at_csi_insert;
   logic at_skip_byte;
   logic insert_held;
   logic char_held;

   assign at_csi_insert = advance && state_ff.mode == MODE_CSI && in_byte_ff == CH_AT;
   assign at_skip_byte  = advance && state_ff.mode == MODE_SKIP && !result.valid
                        && in_byte_ff != CH_SO && in_byte_ff != CH_SI
                        && in_byte_ff != CH_DEL;
   assign insert_held   = out_valid_ff && out_action_ff == ACT_INSERT;
   assign char_held     = out_valid_ff && out_action_ff == ACT_CHAR;

   // checks
   `TESF_ASSERT_NOW(a_ready_when_empty, !in_valid_ff, req_tready, "empty input stage not ready")
   `TESF_ASSERT_NEXT(a_insert_issued, at_csi_insert, insert_held, "insert not registered")
   `TESF_ASSERT_NEXT(a_skip_to_idle, at_skip_byte, state_ff.mode == MODE_IDLE, "skip not left")
   `TESF_ASSERT_NOW(a_char_has_no_count, char_held, out_count_ff == '0, "char with a count")

endmodule
`default_nettype wire

// ----- hw/rtl/tesf_parser.sv -----
// next-state and result decode for one byte of the stream
`default_nettype none
module tesf_parser
   import tesf_pkg::*;
(
   input  wire logic [7:0]      in_byte,
   input  wire tesf_state_type  cur_state,
   output tesf_state_type       nxt_state,
   output tesf_result_type      result
);

   logic [PARAM_WIDTH+3:0] param_x10;
   logic [3:0]             digit;
   logic [32:0]            param_ext;
   logic [7:0]             digit_off;

   assign digit_off = in_byte - CH_ZERO;
   assign digit     = digit_off[3:0];
   assign param_x10 = ({4'b0, cur_state.first_param} << 3)
                    + ({4'b0, cur_state.first_param} << 1)
                    + {{PARAM_WIDTH{1'b0}}, digit};
   assign param_ext = 33'(cur_state.first_param);

   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      case (in_byte) inside
         CH_BEL, CH_BS, CH_TAB, CH_CR: begin
            result.valid    = 1'b1;
            result.out_char = in_byte;
         end
         CH_LF, CH_FF, CH_VT: begin
            result.valid    = 1'b1;
            result.out_char = CH_LF;
         end
         CH_SO, CH_SI, CH_DEL: begin
         end
         default: begin
            case (cur_state.mode)
               MODE_IDLE: begin
                  if (in_byte == CH_ESC) begin
                     nxt_state.mode = MODE_ESC;
                  end else if (in_byte == CH_CSI) begin
                     nxt_state.mode        = MODE_CSI;
                     nxt_state.sep_count   = '0;
                     nxt_state.first_param = '0;
                  end else begin
                     result.valid    = 1'b1;
                     result.out_char = in_byte;
                  end
               end
               MODE_ESC: begin
                  case (in_byte) inside
                     CH_LBRK: begin
                        nxt_state.mode        = MODE_CSI;
                        nxt_state.sep_count   = '0;
                        nxt_state.first_param = '0;
                     end
                     CH_LOWC, CH_CAN, CH_SUB: nxt_state.mode = MODE_IDLE;
                     CH_UPD, CH_UPE: begin
                        nxt_state.mode  = MODE_IDLE;
                        result.valid    = 1'b1;
                        result.out_char = CH_LF;
                     end
                     default: begin
                     end
                  endcase
               end
               MODE_CSI: begin
                  case (in_byte) inside
                     [CH_ZERO:CH_NINE]: begin
                        // only the first parameter is kept, saturating
                        if (cur_state.sep_count == 8'd0) begin
                           if (param_x10 > {4'b0, PARAM_MAX})
                              nxt_state.first_param = PARAM_MAX;
                           else
                              nxt_state.first_param = param_x10[PARAM_WIDTH-1:0];
                        end
                     end
                     CH_LBRK: nxt_state.mode = MODE_SKIP;
                     CH_ESC:  nxt_state.mode = MODE_ESC;
                     CH_CAN, CH_SUB: nxt_state.mode = MODE_IDLE;
                     CH_SEMI: begin
                        if (cur_state.sep_count != 8'hFF)
                           nxt_state.sep_count = cur_state.sep_count + 8'd1;
                     end
                     CH_AT: begin
                        nxt_state.mode = MODE_IDLE;
                        result.valid   = 1'b1;
                        result.action  = ACT_INSERT;
                        if (param_ext > 33'h0FFFF)
                           result.blank_count = '1;
                        else
                           result.blank_count = param_ext[COUNT_WIDTH-1:0];
                     end
                     default: begin
                     end
                  endcase
               end
               default: nxt_state.mode = MODE_IDLE;
            endcase
         end
      endcase
   end

endmodule
`default_nettype wire
